### sv/sspc_pkg.sv
// Shared constants and types for the split-step phase correction pipeline.
`timescale 1ns / 1ps
`default_nettype none
package sspc_pkg;

   localparam int WAVE_BITS     = 24;
   localparam int VELOCITY_BITS = 16;
   localparam int FREQ_BITS     = 12;
   localparam int STEP_BITS     = 32;

   localparam int T_BITS    = FREQ_BITS + STEP_BITS;
   localparam int NUM_BITS  = T_BITS + VELOCITY_BITS;
   localparam int DEN_BITS  = 2 * VELOCITY_BITS;
   localparam int ANG_BITS  = 19;
   localparam int Z_BITS    = ANG_BITS + 1;
   localparam int X_BITS    = 20;
   localparam int PROD_BITS = WAVE_BITS + X_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;

   localparam int REQ_DATA_BITS = ((2 * WAVE_BITS + 2 * VELOCITY_BITS + FREQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * WAVE_BITS + 7) / 8) * 8;

   localparam int CORDIC_STEPS = 16;

   localparam logic [STEP_BITS-1:0] STEP_RESET = 32'd65536;
   localparam logic [Z_BITS-1:0] TWO_PI_Q16  = 20'd411775;
   localparam logic signed [Z_BITS-1:0] PI_Q16      = 20'sd205887;
   localparam logic signed [Z_BITS-1:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic signed [X_BITS-1:0] CORDIC_GAIN = 20'sd39797;

   localparam logic signed [Z_BITS-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
      20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
      20'sd8, 20'sd4, 20'sd2
   };

   // Sample and flags that ride alongside the angle computation.
   typedef struct packed {
      logic signed [WAVE_BITS-1:0] re;
      logic signed [WAVE_BITS-1:0] im;
      logic                        last;
      logic                        neg;
   } side_type;

endpackage
`default_nettype wire

### sv/split_step_phase_correction.sv
// Pipeline: two multiply stages, 60 divider stages, one fold stage, 16 CORDIC
// stages, a product and a rounding stage.
// Throughput: one request per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so a stall holds every stage.
// Reset: synchronous, clears all valid bits and loads step_ff with 65536.
`timescale 1ns / 1ps
`default_nettype none
module split_step_phase_correction (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wen,
   input  wire logic [sspc_pkg::STEP_BITS-1:0]     csr_wdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // wave_re, wave_im, velocity, reference_velocity, freq_index, zero fill
   input  wire logic [sspc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // out_re, out_im
   output logic [sspc_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                                    rsp_tlast
);
   import sspc_pkg::*;

   logic advance;

   logic [STEP_BITS-1:0] step_ff;

   // Request fields.
   logic signed [WAVE_BITS-1:0] f_re, f_im;
   logic [VELOCITY_BITS-1:0] f_v, f_vr;
   logic [FREQ_BITS-1:0] f_freq;

   // Stage 1.
   logic s1_valid_ff;
   logic [T_BITS-1:0] s1_t_ff, s1_t_in;
   logic [DEN_BITS-1:0] s1_den_ff, s1_den_in;
   logic [VELOCITY_BITS-1:0] s1_diff_ff, s1_diff_in;
   side_type s1_side_ff, s1_side_in;

   // Divider stages; index 0 is loaded by the second multiply.
   logic div_valid_ff [NUM_BITS+1];
   logic [NUM_BITS-1:0] div_num_ff [NUM_BITS+1];
   logic [DEN_BITS-1:0] div_den_ff [NUM_BITS+1];
   logic [DEN_BITS-1:0] div_rem_ff [NUM_BITS+1];
   logic [ANG_BITS-1:0] div_q_ff [NUM_BITS+1];
   side_type div_side_ff [NUM_BITS+1];
   logic [DEN_BITS-1:0] div_rem_in [NUM_BITS];
   logic [ANG_BITS-1:0] div_q_in [NUM_BITS];

   // CORDIC stages; index 0 is loaded by the fold stage.
   logic cor_valid_ff [CORDIC_STEPS+1];
   logic signed [X_BITS-1:0] cor_x_ff [CORDIC_STEPS+1];
   logic signed [X_BITS-1:0] cor_y_ff [CORDIC_STEPS+1];
   logic signed [Z_BITS-1:0] cor_z_ff [CORDIC_STEPS+1];
   logic cor_flip_ff [CORDIC_STEPS+1];
   side_type cor_side_ff [CORDIC_STEPS+1];
   logic signed [X_BITS-1:0] cor_x_in [CORDIC_STEPS];
   logic signed [X_BITS-1:0] cor_y_in [CORDIC_STEPS];
   logic signed [Z_BITS-1:0] cor_z_in [CORDIC_STEPS];
   logic signed [Z_BITS-1:0] fold_z_in;
   logic fold_flip_in;

   // Product stage.
   logic pr_valid_ff, pr_last_ff;
   logic signed [PROD_BITS-1:0] pr_rx_ff, pr_iy_ff, pr_ry_ff, pr_ix_ff;
   logic signed [X_BITS-1:0] pr_x, pr_y;

   // Output register.
   logic rsp_valid_ff, rsp_last_ff;
   logic signed [WAVE_BITS-1:0] rsp_re_ff, rsp_im_ff, rsp_re_in, rsp_im_in;

   function automatic logic signed [WAVE_BITS-1:0] round_sat(
      input logic signed [SUM_BITS-1:0] s);
      logic signed [SUM_BITS-1:0] r;
      logic signed [SUM_BITS-1:0] hi;
      logic signed [SUM_BITS-1:0] lo;
      r  = (s + SUM_BITS'(32768)) >>> 16;
      hi = SUM_BITS'((1 << (WAVE_BITS - 1)) - 1);
      lo = -SUM_BITS'(1 << (WAVE_BITS - 1));
      if (r > hi) begin
         return hi[WAVE_BITS-1:0];
      end else if (r < lo) begin
         return lo[WAVE_BITS-1:0];
      end
      return r[WAVE_BITS-1:0];
   endfunction

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   assign f_re   = req_tdata[WAVE_BITS-1:0];
   assign f_im   = req_tdata[2*WAVE_BITS-1:WAVE_BITS];
   assign f_v    = req_tdata[2*WAVE_BITS+VELOCITY_BITS-1:2*WAVE_BITS];
   assign f_vr   = req_tdata[2*WAVE_BITS+2*VELOCITY_BITS-1:2*WAVE_BITS+VELOCITY_BITS];
   assign f_freq = req_tdata[2*WAVE_BITS+2*VELOCITY_BITS+FREQ_BITS-1:
                             2*WAVE_BITS+2*VELOCITY_BITS];

   // A zero velocity forces a zero numerator and a unit divisor, so the angle is zero.
   always_comb begin
      s1_t_in         = T_BITS'(f_freq) * T_BITS'(step_ff);
      s1_side_in.re   = f_re;
      s1_side_in.im   = f_im;
      s1_side_in.last = req_tlast;
      s1_side_in.neg  = f_v > f_vr;
      if (f_v == '0 || f_vr == '0) begin
         s1_den_in  = DEN_BITS'(1);
         s1_diff_in = '0;
      end else begin
         s1_den_in  = DEN_BITS'(f_v) * DEN_BITS'(f_vr);
         s1_diff_in = (f_v > f_vr) ? (f_v - f_vr) : (f_vr - f_v);
      end
   end

   // Restoring division, one numerator bit per stage, with the quotient
   // kept reduced modulo two pi as it is built.
   always_comb begin
      logic [DEN_BITS:0] rsh;
      logic [ANG_BITS:0] q2;
      for (int k = 0; k < NUM_BITS; k++) begin
         rsh = {div_rem_ff[k], div_num_ff[k][NUM_BITS-1-k]};
         q2  = {div_q_ff[k], 1'b0};
         if (rsh >= {1'b0, div_den_ff[k]}) begin
            rsh = rsh - {1'b0, div_den_ff[k]};
            q2  = q2 + (ANG_BITS+1)'(1);
         end
         if (q2 >= TWO_PI_Q16) begin
            q2 = q2 - TWO_PI_Q16;
         end
         div_rem_in[k] = rsh[DEN_BITS-1:0];
         div_q_in[k]   = q2[ANG_BITS-1:0];
      end
   end

   // Apply the sign, wrap into plus or minus pi, then fold into plus or minus half pi.
   always_comb begin
      logic signed [Z_BITS-1:0] a;
      a = {1'b0, div_q_ff[NUM_BITS]};
      if (div_side_ff[NUM_BITS].neg) begin
         a = -a;
      end
      if (a > PI_Q16) begin
         a = a - TWO_PI_Q16;
      end
      if (a < -PI_Q16) begin
         a = a + TWO_PI_Q16;
      end
      fold_flip_in = 1'b0;
      if (a > HALF_PI_Q16) begin
         a            = a - PI_Q16;
         fold_flip_in = 1'b1;
      end else if (a < -HALF_PI_Q16) begin
         a            = a + PI_Q16;
         fold_flip_in = 1'b1;
      end
      fold_z_in = a;
   end

   always_comb begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (!cor_z_ff[i][Z_BITS-1]) begin
            cor_x_in[i] = cor_x_ff[i] - (cor_y_ff[i] >>> i);
            cor_y_in[i] = cor_y_ff[i] + (cor_x_ff[i] >>> i);
            cor_z_in[i] = cor_z_ff[i] - ATAN_TABLE[i];
         end else begin
            cor_x_in[i] = cor_x_ff[i] + (cor_y_ff[i] >>> i);
            cor_y_in[i] = cor_y_ff[i] - (cor_x_ff[i] >>> i);
            cor_z_in[i] = cor_z_ff[i] + ATAN_TABLE[i];
         end
      end
   end

   assign pr_x = cor_flip_ff[CORDIC_STEPS] ? -cor_x_ff[CORDIC_STEPS] : cor_x_ff[CORDIC_STEPS];
   assign pr_y = cor_flip_ff[CORDIC_STEPS] ? -cor_y_ff[CORDIC_STEPS] : cor_y_ff[CORDIC_STEPS];

   assign rsp_re_in = round_sat(SUM_BITS'(pr_rx_ff) - SUM_BITS'(pr_iy_ff));
   assign rsp_im_in = round_sat(SUM_BITS'(pr_ry_ff) + SUM_BITS'(pr_ix_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_wen) begin
         step_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= NUM_BITS; k++) begin
            div_valid_ff[k] <= 1'b0;
         end
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            cor_valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         s1_valid_ff     <= req_tvalid;
         div_valid_ff[0] <= s1_valid_ff;
         for (int k = 0; k < NUM_BITS; k++) begin
            div_valid_ff[k+1] <= div_valid_ff[k];
         end
         cor_valid_ff[0] <= div_valid_ff[NUM_BITS];
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            cor_valid_ff[i+1] <= cor_valid_ff[i];
         end
         pr_valid_ff  <= cor_valid_ff[CORDIC_STEPS];
         rsp_valid_ff <= pr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_t_ff    <= s1_t_in;
         s1_den_ff  <= s1_den_in;
         s1_diff_ff <= s1_diff_in;
         s1_side_ff <= s1_side_in;

         div_num_ff[0]  <= NUM_BITS'(s1_t_ff) * NUM_BITS'(s1_diff_ff);
         div_den_ff[0]  <= s1_den_ff;
         div_rem_ff[0]  <= '0;
         div_q_ff[0]    <= '0;
         div_side_ff[0] <= s1_side_ff;
         for (int k = 0; k < NUM_BITS; k++) begin
            div_num_ff[k+1]  <= div_num_ff[k];
            div_den_ff[k+1]  <= div_den_ff[k];
            div_rem_ff[k+1]  <= div_rem_in[k];
            div_q_ff[k+1]    <= div_q_in[k];
            div_side_ff[k+1] <= div_side_ff[k];
         end

         cor_x_ff[0]    <= CORDIC_GAIN;
         cor_y_ff[0]    <= '0;
         cor_z_ff[0]    <= fold_z_in;
         cor_flip_ff[0] <= fold_flip_in;
         cor_side_ff[0] <= div_side_ff[NUM_BITS];
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            cor_x_ff[i+1]    <= cor_x_in[i];
            cor_y_ff[i+1]    <= cor_y_in[i];
            cor_z_ff[i+1]    <= cor_z_in[i];
            cor_flip_ff[i+1] <= cor_flip_ff[i];
            cor_side_ff[i+1] <= cor_side_ff[i];
         end

         pr_rx_ff   <= PROD_BITS'(cor_side_ff[CORDIC_STEPS].re) * PROD_BITS'(pr_x);
         pr_iy_ff   <= PROD_BITS'(cor_side_ff[CORDIC_STEPS].im) * PROD_BITS'(pr_y);
         pr_ry_ff   <= PROD_BITS'(cor_side_ff[CORDIC_STEPS].re) * PROD_BITS'(pr_y);
         pr_ix_ff   <= PROD_BITS'(cor_side_ff[CORDIC_STEPS].im) * PROD_BITS'(pr_x);
         pr_last_ff <= cor_side_ff[CORDIC_STEPS].last;

         rsp_re_ff   <= rsp_re_in;
         rsp_im_ff   <= rsp_im_in;
         rsp_last_ff <= pr_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_im_ff, rsp_re_ff});

endmodule
`default_nettype wire
